// ===== design/srs_pkg.sv =====
// Package for the stereo linear resampler: shared constants and types.
// Depends on nothing; every other design file refers to it by scoped names.
package srs_pkg;

	localparam int TARGET_RATE_DEF = 48000;
	localparam int SAMPLE_BITS_DEF = 24;
	localparam int PHASE_FRAC_DEF  = 20;

	// Source rate register: width and value after reset.
	localparam int RATE_W     = 18;
	localparam int RATE_RESET = 48000;

	// Integer bits kept in the phase accumulator above the fraction.
	localparam int PHASE_INT_BITS = 3;

	// At most this many output frames per input frame.
	localparam int MAX_RESULTS = 7;
	localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

	// Status of the step divider as seen by the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== design/srs_in_if.sv =====
// Channel interfaces of the stereo linear resampler: input frames, output
// frames and the source rate write. Depends on srs_pkg for default widths.
interface srs_in_if #(
	parameter int SAMPLE_BITS = srs_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_in;
	logic signed [SAMPLE_BITS-1:0] right_in;

	modport source (output valid, output left_in, output right_in, input ready);
	modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface srs_out_if #(
	parameter int SAMPLE_BITS = srs_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] left_out;
	logic signed [SAMPLE_BITS-1:0] right_out;
	logic                          last_of_run;

	modport source (output valid, output left_out, output right_out,
		output last_of_run, input ready);
	modport sink   (input valid, input left_out, input right_out,
		input last_of_run, output ready);
endinterface

interface srs_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [srs_pkg::RATE_W-1:0]  source_rate;

	modport source (output valid, output source_rate, input ready);
	modport sink   (input valid, input source_rate, output ready);
endinterface

// ===== design/srs_step_div.sv =====
// Phase step unit: floor(rate * 2^FRAC_BITS / TARGET_RATE) by multiplying with a
// rounded-up reciprocal, in two passes of one narrow multiplier.
// Depends on srs_pkg for the status struct and the default widths.
module srs_step_div #(
	parameter int RATE_W      = srs_pkg::RATE_W,
	parameter int FRAC_BITS   = srs_pkg::PHASE_FRAC_DEF,
	parameter int TARGET_RATE = srs_pkg::TARGET_RATE_DEF,
	parameter int STEP_W      = srs_pkg::PHASE_FRAC_DEF + srs_pkg::PHASE_INT_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [RATE_W-1:0]  rate,
	output srs_pkg::div_stat_t stat,
	output logic [STEP_W-1:0]  step
);
	// With SH extra shift bits the rounded-up reciprocal gives the exact floor
	// for every rate of RATE_W bits: the rate times the rounding error of the
	// reciprocal stays below 2^SH, so it never carries into the integer part.
	localparam int TW = $clog2(TARGET_RATE + 1);
	localparam int SH = RATE_W + TW;
	localparam int MW = FRAC_BITS + RATE_W + 2;
	localparam int LW = MW / 2;
	localparam int HW = MW - LW;
	localparam int PW = RATE_W + HW;
	localparam int SW = RATE_W + MW;

	localparam logic [MW-1:0] RECIP = MW'(((128'(1) << (FRAC_BITS + SH))
		+ 128'(TARGET_RATE - 1)) / 128'(TARGET_RATE));
	localparam logic [LW-1:0] RECIP_LO = RECIP[LW-1:0];
	localparam logic [HW-1:0] RECIP_HI = RECIP[MW-1:LW];

	logic [RATE_W-1:0]    rate_q;
	logic [RATE_W+LW-1:0] lo_q;
	logic [STEP_W-1:0]    step_q;
	logic                 busy_q;
	logic                 hi_q;
	logic                 done_q;

	logic [HW-1:0]        coef;
	logic [PW-1:0]        prod;
	logic [SW-1:0]        sum;

	// The first pass multiplies by the low half of the reciprocal, the second
	// by the high half; the second pass adds both partial products.
	always_comb begin
		coef = hi_q ? RECIP_HI : HW'(RECIP_LO);
		prod = PW'(rate_q) * PW'(coef);
		sum  = {prod, LW'(0)} + SW'(lo_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			hi_q   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && hi_q;
			if (start) begin
				busy_q <= 1'b1;
				hi_q   <= 1'b0;
			end else if (busy_q) begin
				if (hi_q) begin
					busy_q <= 1'b0;
					hi_q   <= 1'b0;
				end else begin
					hi_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rate_q <= rate;
		end
		if (busy_q && !hi_q) begin
			lo_q <= prod[RATE_W+LW-1:0];
		end
		if (busy_q && hi_q) begin
			step_q <= STEP_W'(sum >> SH);
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign step      = step_q;
endmodule

// ===== design/srs_interp.sv =====
// Shared interpolation unit: prev + ((cur - prev) * frac) >>> FRAC_BITS.
// One multiply register stage; used once per channel. Depends on srs_pkg.
module srs_interp #(
	parameter int SAMPLE_BITS = srs_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = srs_pkg::PHASE_FRAC_DEF
) (
	input  logic                          clk,
	input  logic signed [SAMPLE_BITS-1:0] a,
	input  logic signed [SAMPLE_BITS-1:0] b,
	input  logic        [FRAC_BITS-1:0]   frac,
	output logic signed [SAMPLE_BITS-1:0] res
);
	localparam int PW = SAMPLE_BITS + FRAC_BITS + 2;

	logic signed [SAMPLE_BITS:0]   diff;
	logic signed [FRAC_BITS:0]     frac_s;
	logic signed [PW-1:0]          prod;
	logic signed [PW-1:0]          prod_s1;
	logic signed [SAMPLE_BITS-1:0] a_s1;
	logic signed [PW-1:0]          shifted;

	always_comb begin
		diff   = {b[SAMPLE_BITS-1], b} - {a[SAMPLE_BITS-1], a};
		frac_s = {1'b0, frac};
		prod   = PW'(diff) * PW'(frac_s);
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		a_s1    <= a;
	end

	// Arithmetic shift rounds toward minus infinity; the sum wraps to the sample width.
	always_comb begin
		shifted = prod_s1 >>> FRAC_BITS;
		res     = a_s1 + shifted[SAMPLE_BITS-1:0];
	end
endmodule

// ===== design/stereo_linear_resampler.sv =====
// Top level of the stereo linear resampler: sequencer, frame and phase state.
// Depends on srs_pkg, the channel interfaces, srs_step_div and srs_interp.
//
//  channel    | dir | payload                               | transfer when
//  -----------+-----+---------------------------------------+---------------------
//  frame_in   | in  | left_in, right_in                     | valid && ready
//  frame_out  | out | left_out, right_out, last_of_run      | valid && ready
//  cfg        | in  | source_rate                           | valid && ready
//
// Sequence: an accepted frame that yields k output frames (k from 1 to 7) keeps
// frame_in.ready low until its finish state is done, and so does one that yields
// none; the first frame after reset only primes the store and ready stays high.
// Every output frame takes a check, two passes through the one shared
// multiplier (left, then right) and a load.
// A source_rate write runs the step unit, a reciprocal multiply in two passes of
// its own narrow multiplier; neither channel is ready until the unit reports done.
// Reset clears the stored frame, the phase and the primed flag and loads the
// step for the reset source rate. A stalled frame_out holds the sequencer before
// the next multiply, but the last output of a frame may wait while a new
// input frame is taken.
module stereo_linear_resampler #(
	parameter int TARGET_RATE     = srs_pkg::TARGET_RATE_DEF,
	parameter int SAMPLE_BITS     = srs_pkg::SAMPLE_BITS_DEF,
	parameter int PHASE_FRAC_BITS = srs_pkg::PHASE_FRAC_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	srs_in_if.sink     frame_in,
	srs_out_if.source  frame_out,
	srs_cfg_if.sink    cfg
);
	localparam int PHASE_W = PHASE_FRAC_BITS + srs_pkg::PHASE_INT_BITS;
	localparam int CNT_W   = srs_pkg::RES_CNT_W;

	// Step for the reset rate, worked out at elaboration.
	localparam logic [PHASE_W-1:0] STEP_RESET =
		PHASE_W'((64'(srs_pkg::RATE_RESET) << PHASE_FRAC_BITS) / 64'(TARGET_RATE));
	localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << PHASE_FRAC_BITS;
	localparam logic [CNT_W-1:0]   LAST_IDX  = CNT_W'(srs_pkg::MAX_RESULTS - 1);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_DIV   = 7'b0000010,
		ST_CHECK = 7'b0000100,
		ST_MUL_L = 7'b0001000,
		ST_MUL_R = 7'b0010000,
		ST_LOAD  = 7'b0100000,
		ST_FIN   = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_nx;

	logic                          primed_q;
	logic        [PHASE_W-1:0]     phase_q;
	logic        [PHASE_W-1:0]     step_q;
	logic        [CNT_W-1:0]       n_q;
	logic signed [SAMPLE_BITS-1:0] prev_l_q;
	logic signed [SAMPLE_BITS-1:0] prev_r_q;
	logic signed [SAMPLE_BITS-1:0] cur_l_q;
	logic signed [SAMPLE_BITS-1:0] cur_r_q;
	logic signed [SAMPLE_BITS-1:0] left_res_q;

	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_l_q;
	logic signed [SAMPLE_BITS-1:0] out_r_q;
	logic                          out_last_q;

	logic                          in_xfer;
	logic                          cfg_xfer;
	logic                          out_xfer;
	logic                          out_free;
	logic                          below_one;
	logic        [PHASE_W-1:0]     phase_adv;
	logic                          more;

	srs_pkg::div_stat_t            div_stat;
	logic        [PHASE_W-1:0]     div_step;

	logic signed [SAMPLE_BITS-1:0] mul_a;
	logic signed [SAMPLE_BITS-1:0] mul_b;
	logic signed [SAMPLE_BITS-1:0] mul_res;

	// Handshakes. A rate write wins over a frame offered in the same cycle.
	assign cfg.ready      = (state_q == ST_IDLE);
	assign frame_in.ready = (state_q == ST_IDLE) && !cfg.valid;
	assign cfg_xfer       = cfg.valid && cfg.ready;
	assign in_xfer        = frame_in.valid && frame_in.ready;
	assign out_xfer       = frame_out.valid && frame_out.ready;

	// The output register is free if empty or being drained this cycle; once we
	// leave the check state it stays free until the load after both multiply states.
	assign out_free  = !out_valid_q || frame_out.ready;
	assign below_one = (phase_q < PHASE_ONE);
	assign phase_adv = phase_q + step_q;
	assign more      = (phase_adv < PHASE_ONE) && (n_q < LAST_IDX);

	srs_step_div #(
		.RATE_W      (srs_pkg::RATE_W),
		.FRAC_BITS   (PHASE_FRAC_BITS),
		.TARGET_RATE (TARGET_RATE),
		.STEP_W      (PHASE_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cfg_xfer),
		.rate   (cfg.source_rate),
		.stat   (div_stat),
		.step   (div_step)
	);

	// The multiplier sees the left pair in MUL_L and the right pair otherwise.
	always_comb begin
		if (state_q == ST_MUL_L) begin
			mul_a = prev_l_q;
			mul_b = cur_l_q;
		end else begin
			mul_a = prev_r_q;
			mul_b = cur_r_q;
		end
	end

	srs_interp #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.FRAC_BITS   (PHASE_FRAC_BITS)
	) u_interp (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.frac (phase_q[PHASE_FRAC_BITS-1:0]),
		.res  (mul_res)
	);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cfg_xfer) begin
					state_nx = ST_DIV;
				end else if (in_xfer && primed_q) begin
					state_nx = ST_CHECK;
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					state_nx = ST_IDLE;
				end
			end
			ST_CHECK: begin
				if (!below_one) begin
					state_nx = ST_FIN;
				end else if (out_free) begin
					state_nx = ST_MUL_L;
				end
			end
			ST_MUL_L: state_nx = ST_MUL_R;
			ST_MUL_R: state_nx = ST_LOAD;
			ST_LOAD:  state_nx = more ? ST_CHECK : ST_FIN;
			ST_FIN:   state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			primed_q    <= 1'b0;
			phase_q     <= '0;
			step_q      <= STEP_RESET;
			n_q         <= '0;
			prev_l_q    <= '0;
			prev_r_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;

			if (state_q == ST_DIV && div_stat.done) begin
				step_q <= div_step;
			end

			// The very first frame only fills the previous-frame store.
			if (in_xfer && !primed_q) begin
				prev_l_q <= frame_in.left_in;
				prev_r_q <= frame_in.right_in;
				primed_q <= 1'b1;
			end

			if (state_q == ST_LOAD) begin
				phase_q <= phase_adv;
				n_q     <= n_q + CNT_W'(1);
			end

			// Drop the phase by one input period, saturating at zero when the
			// output cap stopped the run short of one.
			if (state_q == ST_FIN) begin
				phase_q  <= below_one ? '0 : phase_q - PHASE_ONE;
				n_q      <= '0;
				prev_l_q <= cur_l_q;
				prev_r_q <= cur_r_q;
			end

			if (state_q == ST_LOAD) begin
				out_valid_q <= 1'b1;
			end else if (out_xfer) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Data registers.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cur_l_q <= frame_in.left_in;
			cur_r_q <= frame_in.right_in;
		end
		if (state_q == ST_MUL_R) begin
			left_res_q <= mul_res;
		end
		if (state_q == ST_LOAD) begin
			out_l_q    <= left_res_q;
			out_r_q    <= mul_res;
			out_last_q <= !more;
		end
	end

	assign frame_out.valid       = out_valid_q;
	assign frame_out.left_out    = out_l_q;
	assign frame_out.right_out   = out_r_q;
	assign frame_out.last_of_run = out_last_q;
endmodule

// ===== design/srs_checker.sv =====
// Port-level checker for the stereo linear resampler, bound to the top level.
// Depends on srs_pkg for widths; sees only the top level's ports.
module srs_checker #(
	parameter int SAMPLE_BITS = srs_pkg::SAMPLE_BITS_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_ready,
	input logic                   cfg_valid,
	input logic                   cfg_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [SAMPLE_BITS-1:0] out_left,
	input logic [SAMPLE_BITS-1:0] out_right,
	input logic                   out_last
);
	// A result that is offered stays offered, unchanged, until taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_left)
			&& $stable(out_right) && $stable(out_last))
		else $error("output frame dropped or changed while stalled");

	// A rate write starts the step unit, so no frame can be taken next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !in_ready)
		else $error("input ready right after a rate write");

	// The input side is only ever open when the rate port is open as well.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> cfg_ready)
		else $error("input ready while rate port is busy");

	// A new result is produced only while the block is busy with a frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready && !cfg_ready))
		else $error("result appeared while the block was idle");
endmodule

bind stereo_linear_resampler srs_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_srs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (frame_in.ready),
	.cfg_valid (cfg.valid),
	.cfg_ready (cfg.ready),
	.out_valid (frame_out.valid),
	.out_ready (frame_out.ready),
	.out_left  (frame_out.left_out),
	.out_right (frame_out.right_out),
	.out_last  (frame_out.last_of_run)
);
